FILE: hw/rtl/mdd_pkg.sv
// Shared types and constants for the marker delimited deframer.
`default_nettype none
package mdd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned MARKER_W    = 32;
   localparam int unsigned LOOKAHEAD_N = 3;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [MARKER_W-1:0] HEAD_RESET = 32'hCF77_07AB;
   localparam logic [MARKER_W-1:0] TAIL_RESET = 32'hAB07_77CF;

   localparam logic CSR_IDX_HEAD = 1'b0;
   localparam logic CSR_IDX_TAIL = 1'b1;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_COMMIT  = 2'd1,
      KIND_DISCARD = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EV_DATA = 2'd0,
      EV_HEAD = 2'd1,
      EV_TAIL = 2'd2
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type        kind;
      logic [BYTE_W-1:0]  data;
   } event_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mdd_req_if.sv
// Input byte channel interface.
`default_nettype none
interface mdd_req_if;
   import mdd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);

endinterface
`default_nettype wire

FILE: hw/rtl/mdd_rsp_if.sv
// Result channel interface.
`default_nettype none
interface mdd_rsp_if;
   import mdd_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        result_kind;
   logic [BYTE_W-1:0] out_byte;
   logic              first_of_frame;

   modport source (output valid, output result_kind, output out_byte,
                   output first_of_frame, input ready);
   modport sink (input valid, input result_kind, input out_byte,
                 input first_of_frame, output ready);

endinterface
`default_nettype wire

FILE: hw/rtl/mdd_front.sv
// Front end: lookahead window and marker classification of received bytes.
`default_nettype none
module mdd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   mdd_req_if.sink                req_chan,
   input  wire logic [31:0]       head_marker,
   input  wire logic [31:0]       tail_marker,
   output mdd_pkg::event_type     push_data,
   output logic                   push_valid,
   input  wire logic              push_ready
);
   import mdd_pkg::*;

   logic [BYTE_W-1:0]   la_ff [LOOKAHEAD_N];
   logic [BYTE_W-1:0]   la_in [LOOKAHEAD_N];
   logic [1:0]          la_cnt_ff;
   logic [1:0]          la_cnt_in;
   logic [MARKER_W-1:0] window;
   logic                accept;
   logic                full;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;
   assign full = (la_cnt_ff == 2'(LOOKAHEAD_N));
   assign window = {la_ff[0], la_ff[1], la_ff[2], req_chan.in_byte};

   always_comb begin
      la_in = la_ff;
      la_cnt_in = la_cnt_ff;
      push_valid = 1'b0;
      push_data.kind = EV_DATA;
      push_data.data = la_ff[0];
      if (accept) begin
         if (!full) begin
            la_in[la_cnt_ff] = req_chan.in_byte;
            la_cnt_in = la_cnt_ff + 2'd1;
         end else if (window == tail_marker) begin
            push_valid = 1'b1;
            push_data.kind = EV_TAIL;
            la_cnt_in = 2'd0;
         end else if (window == head_marker) begin
            push_valid = 1'b1;
            push_data.kind = EV_HEAD;
            la_cnt_in = 2'd0;
         end else begin
            push_valid = 1'b1;
            la_in[0] = la_ff[1];
            la_in[1] = la_ff[2];
            la_in[2] = req_chan.in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      la_ff <= la_in;
      if (reset) begin
         la_cnt_ff <= 2'd0;
      end else begin
         la_cnt_ff <= la_cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/mdd_queue.sv
// Short event queue between the front end and the back end.
`default_nettype none
module mdd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire mdd_pkg::event_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output mdd_pkg::event_type     pop_data
);
   import mdd_pkg::*;

   event_type              mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff;
   logic [QUEUE_CNT_W-1:0] cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data = mem[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/mdd_back.sv
// Back end: frame tracking and the registered result stage.
`default_nettype none
module mdd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire mdd_pkg::event_type pop_data,
   mdd_rsp_if.source               rsp_chan
);
   import mdd_pkg::*;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [1:0]        kind_ff;
   logic [1:0]        kind_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              first_ff;
   logic              first_in;
   logic              fhb_ff;
   logic              fhb_in;
   logic              take;

   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in = kind_ff;
      byte_in = byte_ff;
      first_in = first_ff;
      fhb_in = fhb_ff;
      if (take) begin
         case (pop_data.kind)
            EV_DATA: begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_DATA;
               byte_in = pop_data.data;
               first_in = !fhb_ff;
               fhb_in = 1'b1;
            end
            EV_HEAD: begin
               rsp_valid_in = fhb_ff;
               kind_in = KIND_DISCARD;
               byte_in = '0;
               first_in = 1'b0;
               fhb_in = 1'b0;
            end
            EV_TAIL: begin
               rsp_valid_in = fhb_ff;
               kind_in = KIND_COMMIT;
               byte_in = '0;
               first_in = 1'b0;
               fhb_in = 1'b0;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      first_ff <= first_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fhb_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fhb_ff <= fhb_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.result_kind = kind_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.first_of_frame = first_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/marker_delimited_deframer_core.sv
// Top level of the marker delimited deframer with its register port.
// Throughput: one byte per cycle while the queue has room; a four-entry queue
// absorbs result stalls. A result passes through the queue and the registered
// result stage; payload bytes are held back by the three-byte lookahead window.
// Reset clears the lookahead count, queue, frame flag and result valid, and
// restores both marker registers to their default values.
`default_nettype none
module marker_delimited_deframer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mdd_req_if.sink                               req_chan,
   mdd_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mdd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mdd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mdd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import mdd_pkg::*;

   logic [MARKER_W-1:0] head_ff;
   logic [MARKER_W-1:0] head_in;
   logic [MARKER_W-1:0] tail_ff;
   logic [MARKER_W-1:0] tail_in;
   logic                csr_wr;
   logic                csr_idx;
   event_type           push_data;
   logic                push_valid;
   logic                push_ready;
   event_type           pop_data;
   logic                pop_valid;
   logic                pop_ready;

   assign csr_pready = 1'b1;
   assign csr_idx = csr_paddr[2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_idx == CSR_IDX_TAIL) ? tail_ff : head_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (csr_wr && csr_idx == CSR_IDX_HEAD) begin
         head_in = csr_pwdata;
      end
      if (csr_wr && csr_idx == CSR_IDX_TAIL) begin
         tail_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         tail_ff <= TAIL_RESET;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   mdd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .head_marker (head_ff),
      .tail_marker (tail_ff),
      .push_data   (push_data),
      .push_valid  (push_valid),
      .push_ready  (push_ready)
   );

   mdd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   // Marker results carry no byte and no first-of-frame flag.
   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_kind != KIND_DATA
      |-> rsp_chan.out_byte == '0 && !rsp_chan.first_of_frame)
      else $error("marker result carries payload bits");

   // Input backpressure only follows a stalled result transfer.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> $past(rsp_chan.valid && !rsp_chan.ready))
      else $error("input stalled without a stalled result");

   // A fresh result follows queue traffic of the previous cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(pop_valid))
      else $error("result appeared without a queued event");
`endif

endmodule
`default_nettype wire
